// ===== design/sliding_window_stats_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding window statistics assertion macros
// Shared assertion helpers for the sliding window statistics core.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_STATS_CORE_DEFINES_SVH
`define SLIDING_WINDOW_STATS_CORE_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define SWS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SWS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/sws_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window statistics package
// Item types, register indexes, controller states and control structs.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int FILL_W    = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_MIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_MAX     = 2'd2;

    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic              func;
        logic [DATA_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [FILL_W-1:0] fill_count;
        logic [DATA_W-1:0] average;
        logic [DATA_W-1:0] minimum;
        logic [DATA_W-1:0] maximum;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_SCAN,
        S_DIV_INIT,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_old;
        logic update;
        logic scan;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic div_done;
    } t_status;

endpackage

// ===== design/sws_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sws_datapath.sv =====
// ----------------------------------------------------------------------------
// Sliding window statistics datapath
// Sample ring, running sum, min/max scan, serial divider and result register.
// ----------------------------------------------------------------------------
module sws_datapath
    import sws_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in_item             i_in,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output t_out_item            o_out
);

    localparam int LW  = $clog2(DEPTH + 1);
    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW  = DATA_W + LW;
    localparam int DCW = $clog2(SW + 1);
    localparam logic [LW-1:0] LEN_RST = LW'((64 > DEPTH) ? DEPTH : 64);

    logic [LW-1:0]     r_len, n_len;
    logic [AW-1:0]     r_pos, n_pos;
    logic [LW-1:0]     r_count, n_count;
    logic [SW-1:0]     r_sum, n_sum;
    logic              r_track_min, r_track_max;
    t_in_item          r_item;
    logic [LW-1:0]     r_idx;
    logic              r_pend;
    logic [DATA_W-1:0] r_min, r_max;
    logic [SW-1:0]     r_quo;
    logic [LW-1:0]     r_rem;
    logic [DCW-1:0]    r_dcnt;
    t_out_item         r_out;

    logic [DATA_W-1:0] rd_data;
    logic [AW-1:0]     raddr;
    logic              ram_we;
    logic [LW:0]       pos_inc;
    logic              full;
    logic [LW:0]       trial;
    logic              ge;
    logic              nz;

    assign raddr  = i_cmd.scan ? r_idx[AW-1:0] : r_pos;
    assign ram_we = i_cmd.update && (r_item.func == FUNC_PUSH);

    sws_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_item.sample),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    assign full    = (r_count >= r_len);
    assign pos_inc = (LW + 1)'(r_pos) + 1'b1;

    always_comb begin
        n_len   = r_len;
        n_pos   = r_pos;
        n_count = r_count;
        n_sum   = r_sum;
        if (i_cfg_we && (i_cfg_idx == CFG_WINDOW_LENGTH)) begin
            if (i_cfg_data == '0) begin
                n_len = LW'(1);
            end else if (32'(i_cfg_data) > DEPTH) begin
                n_len = LW'(DEPTH);
            end else begin
                n_len = LW'(i_cfg_data);
            end
            n_pos   = '0;
            n_count = '0;
            n_sum   = '0;
        end else if (i_cmd.update) begin
            if (r_item.func == FUNC_CLEAR) begin
                n_pos   = '0;
                n_count = '0;
                n_sum   = '0;
            end else begin
                n_sum = r_sum - (full ? SW'(rd_data) : '0) + SW'(r_item.sample);
                n_pos = (pos_inc >= (LW + 1)'(r_len)) ? '0 : AW'(pos_inc);
                if (!full) begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    // Restoring division, one quotient bit per cycle.
    assign trial = {r_rem, r_quo[SW-1]};
    assign ge    = (trial >= {1'b0, r_count});
    assign nz    = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_RST;
            r_pos       <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_track_min <= 1'b0;
            r_track_max <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_count <= n_count;
            r_sum   <= n_sum;
            if (i_cfg_we && (i_cfg_idx == CFG_TRACK_MIN)) begin
                r_track_min <= i_cfg_data[0];
            end
            if (i_cfg_we && (i_cfg_idx == CFG_TRACK_MAX)) begin
                r_track_max <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
        end
        if (i_cmd.update) begin
            r_idx  <= '0;
            r_pend <= 1'b0;
            r_min  <= ALL_ONES;
            r_max  <= '0;
        end else if (i_cmd.scan) begin
            if (r_idx < r_count) begin
                r_idx  <= r_idx + 1'b1;
                r_pend <= 1'b1;
            end else begin
                r_pend <= 1'b0;
            end
            if (r_pend) begin
                if (rd_data < r_min) begin
                    r_min <= rd_data;
                end
                if (rd_data > r_max) begin
                    r_max <= rd_data;
                end
            end
        end
        if (i_cmd.div_init) begin
            r_quo  <= r_sum;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[SW-2:0], ge};
            r_rem  <= ge ? LW'(trial - {1'b0, r_count}) : LW'(trial);
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.fill_count <= FILL_W'(r_count);
            r_out.average    <= nz ? r_quo[DATA_W-1:0] : '0;
            r_out.minimum    <= (nz && r_track_min) ? r_min : ALL_ONES;
            r_out.maximum    <= (nz && r_track_max) ? r_max : ALL_ONES;
        end
    end

    assign o_status.scan_done = (r_idx == r_count) && !r_pend;
    assign o_status.div_done  = (r_dcnt == DCW'(SW));
    assign o_out              = r_out;

endmodule

// ===== design/sws_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sliding window statistics controller
// Sequences ring update, min/max scan and division, and owns result valid.
// ----------------------------------------------------------------------------
`include "sliding_window_stats_core_defines.svh"

module sws_ctrl
    import sws_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_old = 1'b1;
                n_state      = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `SWS_ASSERT(a_accept_starts, (i_in_valid && o_in_ready) |=> (r_state == S_READ), "accepted item did not start")
    `SWS_ASSERT(a_no_overwrite, o_cmd.out_load |-> (!r_out_valid || i_out_ready), "result overwritten before transfer")
    `SWS_ASSERT(a_valid_drop, $fell(r_out_valid) |-> $past(i_out_ready), "result dropped without transfer")
    `SWS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid), "reset did not idle")

endmodule

// ===== design/sliding_window_stats_core.sv =====
// A push or a clear steps through the read, update, min/max scan and division states before its result is registered.
// The min/max scan reads one stored sample per cycle and the divider makes one quotient bit per cycle.
// Throughput: one item at a time; a new item is taken while the previous result waits.
// Reset (synchronous, active low) empties the window, sets the window length to 64
// (or the built depth if smaller) and turns minimum and maximum tracking off.
// ----------------------------------------------------------------------------
// Sliding window statistics core
// Moving average, minimum and maximum over a ring of 32-bit samples.
// ----------------------------------------------------------------------------
module sliding_window_stats_core
    import sws_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration writes take effect at once. Writing the window length
    // also empties the window, the same as a clear item.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Input items: a push stores a sample, a clear empties the window.
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in,
    // One result per item, held in an output register until transferred.
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out
);

    // The controller only sequences; all storage and arithmetic lives in
    // the datapath. The ring sits in a RAM read once for the evicted sample
    // and then once per valid entry during the min/max scan.
    t_cmd    cmd;
    t_status status;

    sws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sws_datapath #(
        .DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out      (o_out)
    );

endmodule
